[rtl/wfpa_pkg.sv]
// package for the worst-fit partition allocator
// holds sizes, command and status codes, the cell-chain record types
// no dependencies
package wfpa_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_W     = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;

  localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(16);
  localparam logic [CNT_W-1:0] MAX_COUNT    = CNT_W'(MAX_BLOCKS);

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_e;

  // record that walks down the chain, one cell per cycle
  typedef struct packed {
    logic              valid;
    logic [SIZE_W-1:0] req;
    logic              found;
    logic [IDX_W-1:0]  best;
    logic [SIZE_W-1:0] left;
  } scan_t;

  // broadcast update to all cells
  typedef struct packed {
    logic              load;
    logic              clr;
    logic              set;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
  } upd_t;

endpackage

[rtl/wfpa_cell.sv]
// one partition cell: holds size and taken flag, compares against the
// passing scan record and forwards it to the next cell
// depends on wfpa_pkg
module wfpa_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [wfpa_pkg::IDX_W-1:0] idx_i,
  input  logic [wfpa_pkg::CNT_W-1:0] count_i,
  input  wfpa_pkg::upd_t            upd_i,
  input  wfpa_pkg::scan_t           scan_i,
  output wfpa_pkg::scan_t           scan_o,
  output logic                      taken_o
);

  logic [wfpa_pkg::SIZE_W-1:0] size_q;
  logic                        taken_q;
  wfpa_pkg::scan_t             scan_d, scan_q;
  logic                        active;
  logic                        fits;
  logic [wfpa_pkg::SIZE_W-1:0] left;
  logic                        hit;

  assign active = {1'b0, idx_i} < count_i;
  assign hit    = upd_i.idx == idx_i;
  assign fits   = active && !taken_q && (size_q >= scan_i.req);
  assign left   = size_q - scan_i.req;

  always_comb begin
    scan_d = scan_i;
    if (fits && (!scan_i.found || (left > scan_i.left))) begin
      scan_d.found = 1'b1;
      scan_d.best  = idx_i;
      scan_d.left  = left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= 1'b0;
      scan_q  <= '0;
    end else begin
      scan_q <= scan_d;
      if (hit && (upd_i.load || upd_i.clr)) begin
        taken_q <= 1'b0;
      end else if (hit && upd_i.set) begin
        taken_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit && upd_i.load) begin
      size_q <= upd_i.size;
    end
  end

  assign scan_o  = scan_q;
  assign taken_o = taken_q;

endmodule

[rtl/worst_fit_partition_allocator_unit.sv]
// worst-fit allocator: load, free and invalid commands answer in the cycle after
// the input beat; an allocate walks a record down the chain of MAX_BLOCKS cells,
// one cell a cycle, and its result is held pending until the output slot is free
// no input is taken while an allocate is in the chain or awaiting output; a
// stalled result blocks the next input beat
// reset clears every taken flag and sets active_blocks to 16; sizes hold
// whatever was last loaded and are undefined until written
module worst_fit_partition_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  command_i,
  input  logic [wfpa_pkg::IDX_W-1:0]  block_index_i,
  input  logic [wfpa_pkg::SIZE_W-1:0] size_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [wfpa_pkg::IDX_W-1:0]  result_index_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [wfpa_pkg::CNT_W-1:0]  active_blocks_i
);

  wfpa_pkg::state_e            state_d, state_q;
  logic [wfpa_pkg::CNT_W-1:0]  active_q;
  logic [wfpa_pkg::CNT_W-1:0]  count;
  wfpa_pkg::scan_t             chain [wfpa_pkg::MAX_BLOCKS+1];
  logic [wfpa_pkg::MAX_BLOCKS-1:0] taken;
  wfpa_pkg::upd_t              upd;
  logic                        accept, slot_free, in_range, done;
  logic                        out_valid_q;
  logic [1:0]                  status_q, pend_status_q, imm_status;
  logic [wfpa_pkg::IDX_W-1:0]  res_q, pend_res_q;

  assign cfg_ready_o = 1'b1;
  assign count     = (active_q > wfpa_pkg::MAX_COUNT) ? wfpa_pkg::MAX_COUNT : active_q;
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == wfpa_pkg::S_IDLE) && slot_free;
  assign accept    = in_valid_i && in_ready_o;
  assign in_range  = {1'b0, block_index_i} < count;
  assign done      = (state_q == wfpa_pkg::S_SCAN) && chain[wfpa_pkg::MAX_BLOCKS].valid;

  // launch record into the first cell
  always_comb begin
    chain[0].valid = accept && (command_i == wfpa_pkg::CMD_ALLOC);
    chain[0].req   = size_value_i;
    chain[0].found = 1'b0;
    chain[0].best  = '0;
    chain[0].left  = '0;
  end

  always_comb begin
    upd.load = accept && (command_i == wfpa_pkg::CMD_LOAD) && in_range;
    upd.clr  = accept && (command_i == wfpa_pkg::CMD_FREE) && in_range
               && taken[block_index_i];
    upd.set  = done && chain[wfpa_pkg::MAX_BLOCKS].found;
    upd.idx  = done ? chain[wfpa_pkg::MAX_BLOCKS].best : block_index_i;
    upd.size = size_value_i;
  end

  always_comb begin
    imm_status = wfpa_pkg::ST_ERR;
    if (upd.load || upd.clr) begin
      imm_status = wfpa_pkg::ST_OK;
    end
  end

  for (genvar g = 0; g < wfpa_pkg::MAX_BLOCKS; g++) begin : g_cell
    wfpa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (wfpa_pkg::IDX_W'(g)),
      .count_i (count),
      .upd_i   (upd),
      .scan_i  (chain[g]),
      .scan_o  (chain[g+1]),
      .taken_o (taken[g])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wfpa_pkg::S_IDLE: if (accept && command_i == wfpa_pkg::CMD_ALLOC) state_d = wfpa_pkg::S_SCAN;
      wfpa_pkg::S_SCAN: if (done) state_d = wfpa_pkg::S_RESP;
      wfpa_pkg::S_RESP: if (slot_free) state_d = wfpa_pkg::S_IDLE;
      default:          state_d = wfpa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wfpa_pkg::S_IDLE;
      active_q    <= wfpa_pkg::ACTIVE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        active_q <= active_blocks_i;
      end
      if (accept && command_i != wfpa_pkg::CMD_ALLOC) begin
        out_valid_q <= 1'b1;
      end else if (state_q == wfpa_pkg::S_RESP && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      pend_status_q <= chain[wfpa_pkg::MAX_BLOCKS].found ? wfpa_pkg::ST_OK : wfpa_pkg::ST_NOFIT;
      pend_res_q    <= chain[wfpa_pkg::MAX_BLOCKS].found ? chain[wfpa_pkg::MAX_BLOCKS].best
                                                         : '0;
    end
    if (accept && command_i != wfpa_pkg::CMD_ALLOC) begin
      status_q <= imm_status;
      res_q    <= block_index_i;
    end else if (state_q == wfpa_pkg::S_RESP && slot_free) begin
      status_q <= pend_status_q;
      res_q    <= pend_res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_index_o = res_q;

endmodule

[rtl/wfpa_checker.sv]
// port-level checks for the worst-fit allocator, bound to the top level
// depends on wfpa_pkg and worst_fit_partition_allocator_unit
module wfpa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [1:0]                  command_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  status_o,
  input logic [wfpa_pkg::IDX_W-1:0]  result_index_o,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(result_index_o))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_nofit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == wfpa_pkg::ST_NOFIT |-> result_index_o == '0)
    else $error("no-fit result carries a non-zero index");

  // an allocate occupies the chain, so the input side closes next cycle
  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && command_i == wfpa_pkg::CMD_ALLOC |=> !in_ready_o)
    else $error("input accepted during an allocate scan");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration beat refused");

endmodule

bind worst_fit_partition_allocator_unit wfpa_checker u_wfpa_checker (.*);

[dv/worst_fit_partition_allocator_unit_tb.sv]
// self-checking testbench for worst_fit_partition_allocator_unit
// depends on rtl/wfpa_pkg.sv and the allocator rtl; drives valid/ready beats and
// checks every reply against a worst-fit partition table kept in the ledger class
module worst_fit_partition_allocator_unit_tb;
  import wfpa_pkg::*;

  localparam logic [1:0] CMD_BAD   = 2'd3;
  localparam int         IDLE_PCT  = 16;
  localparam int         STALL_LIM = 2000;
  localparam int         PHASE_LEN = 72;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [1:0]          command_i       = CMD_LOAD;
  logic [IDX_W-1:0]    block_index_i   = '0;
  logic [SIZE_W-1:0]   size_value_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [1:0]          status_o;
  logic [IDX_W-1:0]    result_index_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CNT_W-1:0]    active_blocks_i = ACTIVE_RESET;

  bit calm = 1'b0;
  int unsigned quiet_cycles = 0;

  // partition table mirror plus the replies still owed by the block
  class alloc_ledger;
    typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] index;
    } reply_t;

    logic [SIZE_W-1:0] part_size   [MAX_BLOCKS];
    bit                part_taken  [MAX_BLOCKS];
    bit                part_loaded [MAX_BLOCKS];
    logic [CNT_W-1:0]  active_reg;
    reply_t            replies_due [$];
    int unsigned       mismatches;

    function new();
      foreach (part_size[i]) begin
        part_size[i]   = '0;
        part_taken[i]  = 1'b0;
        part_loaded[i] = 1'b0;
      end
      active_reg = ACTIVE_RESET;
      mismatches = 0;
    endfunction

    function void set_active(logic [CNT_W-1:0] value);
      active_reg = value;
    endfunction

    function int unsigned live_count();
      return (active_reg > MAX_COUNT) ? MAX_BLOCKS : active_reg;
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    // an allocate may only scan partitions that have been loaded
    function int first_unloaded();
      for (int i = 0; i < live_count(); i++)
        if (!part_loaded[i]) return i;
      return -1;
    endfunction

    function int pick_taken();
      int unsigned n;
      int unsigned start;
      n = live_count();
      if (n == 0) return -1;
      start = $urandom_range(n - 1);
      for (int k = 0; k < n; k++)
        if (part_taken[(start + k) % n]) return (start + k) % n;
      return -1;
    endfunction

    task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task automatic take_request(logic [1:0] cmd, logic [IDX_W-1:0] idx,
                                logic [SIZE_W-1:0] req);
      reply_t            r;
      int unsigned       n;
      bit                found;
      logic [IDX_W-1:0]  best;
      logic [SIZE_W-1:0] best_left;
      logic [SIZE_W-1:0] left;
      n        = live_count();
      r.status = ST_ERR;
      r.index  = idx;
      case (cmd)
        CMD_LOAD: begin
          if (idx < n) begin
            part_size[idx]   = req;
            part_taken[idx]  = 1'b0;
            part_loaded[idx] = 1'b1;
            r.status         = ST_OK;
          end
        end
        CMD_ALLOC: begin
          found     = 1'b0;
          best      = '0;
          best_left = '0;
          for (int i = 0; i < n; i++) begin
            if (!part_taken[i] && part_size[i] >= req) begin
              left = part_size[i] - req;
              // strict compare keeps the lowest index on a tie
              if (!found || left > best_left) begin
                found     = 1'b1;
                best      = IDX_W'(i);
                best_left = left;
              end
            end
          end
          if (found) begin
            part_taken[best] = 1'b1;
            r.status         = ST_OK;
            r.index          = best;
          end else begin
            r.status = ST_NOFIT;
            r.index  = '0;
          end
        end
        CMD_FREE: begin
          if (idx < n && part_taken[idx]) begin
            part_taken[idx] = 1'b0;
            r.status        = ST_OK;
          end
        end
        default: ;
      endcase
      replies_due.push_back(r);
    endtask

    task automatic match_response(logic [1:0] status, logic [IDX_W-1:0] index);
      reply_t want;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("reply with none owed: status %0d index %0d",
                                  status, index));
      end else begin
        want = replies_due.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
        if (index !== want.index)
          report_mismatch($sformatf("result_index %0d, wanted %0d", index, want.index));
      end
    endtask
  endclass

  alloc_ledger ledger = new();

  worst_fit_partition_allocator_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .block_index_i   (block_index_i),
    .size_value_i    (size_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .result_index_o  (result_index_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .active_blocks_i (active_blocks_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      ledger.match_response(status_o, result_index_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIM) begin
        $display("[worst_fit_partition_allocator_unit] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // valid stays up across back-to-back beats; it only drops for a gap
  task automatic send_item(logic [1:0] cmd, logic [IDX_W-1:0] idx,
                           logic [SIZE_W-1:0] sz);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    block_index_i <= idx;
    size_value_i  <= sz;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.take_request(cmd, idx, sz);
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_active(logic [CNT_W-1:0] value);
    cfg_valid_i     <= 1'b1;
    active_blocks_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ledger.set_active(value);
  endtask

  function automatic logic [SIZE_W-1:0] random_size();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0:       return '0;
      1:       return '1;
      2, 3:    return SIZE_W'($urandom_range(65535));
      default: return SIZE_W'($urandom_range(1000));
    endcase
  endfunction

  task automatic random_item(output logic [1:0] cmd, output logic [IDX_W-1:0] idx,
                             output logic [SIZE_W-1:0] sz);
    int unsigned n;
    int unsigned roll;
    int          pick;
    n    = ledger.live_count();
    roll = $urandom_range(99);
    idx  = IDX_W'($urandom_range(15));
    if (n != 0 && $urandom_range(9) != 0) idx = IDX_W'($urandom_range(n - 1));
    sz = random_size();
    if (roll < 30) begin
      cmd = CMD_LOAD;
      // equal sizes make ties on the leftover
      if (n != 0 && $urandom_range(4) == 0)
        sz = ledger.part_size[$urandom_range(n - 1)];
    end else if (roll < 70) begin
      cmd = CMD_ALLOC;
      // exact fits
      if (n != 0 && $urandom_range(3) == 0)
        sz = ledger.part_size[$urandom_range(n - 1)];
    end else if (roll < 95) begin
      cmd  = CMD_FREE;
      pick = ledger.pick_taken();
      if (pick >= 0 && $urandom_range(3) != 0) idx = IDX_W'(pick);
    end else begin
      cmd = CMD_BAD;
    end
    if (cmd == CMD_ALLOC) begin
      pick = ledger.first_unloaded();
      if (pick >= 0) begin
        cmd = CMD_LOAD;
        idx = IDX_W'(pick);
      end
    end
  endtask

  initial begin : stimulus
    logic [1:0]       cmd;
    logic [IDX_W-1:0] idx;
    logic [SIZE_W-1:0] sz;
    logic [CNT_W-1:0] settings [6];
    settings = '{5'd31, 5'd16, 5'd1, 5'd7, 5'd2, 5'd0};
    settings[5] = CNT_W'($urandom_range(16, 1));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_active(5'd4);
    send_item(CMD_LOAD,  4'd0,  16'd0);
    send_item(CMD_LOAD,  4'd1,  16'hFFFF);
    send_item(CMD_LOAD,  4'd2,  16'd100);
    send_item(CMD_LOAD,  4'd3,  16'd100);
    send_item(CMD_LOAD,  4'd15, 16'd7);
    send_item(CMD_ALLOC, 4'd0,  16'd0);
    send_item(CMD_ALLOC, 4'd5,  16'hFFFF);
    send_item(CMD_ALLOC, 4'd0,  16'd100);
    send_item(CMD_ALLOC, 4'd0,  16'd100);
    send_item(CMD_ALLOC, 4'd0,  16'd0);
    send_item(CMD_ALLOC, 4'd0,  16'd0);
    send_item(CMD_FREE,  4'd2,  16'd0);
    send_item(CMD_FREE,  4'd2,  16'd0);
    send_item(CMD_FREE,  4'd15, 16'd0);
    send_item(CMD_BAD,   4'd9,  16'hFFFF);
    // reload of an allocated partition frees it
    send_item(CMD_LOAD,  4'd1,  16'd50);
    send_item(CMD_ALLOC, 4'd0,  16'd50);
    send_item(CMD_ALLOC, 4'd0,  16'd50);
    drain_replies();

    // no partitions in use at all
    write_active(5'd0);
    send_item(CMD_ALLOC, 4'd0,  16'd1);
    send_item(CMD_LOAD,  4'd0,  16'd10);
    send_item(CMD_FREE,  4'd1,  16'd0);
    drain_replies();

    foreach (settings[p]) begin
      calm = (settings[p] == 5'd16);
      write_active(settings[p]);
      for (int k = 0; k < PHASE_LEN; k++) begin
        random_item(cmd, idx, sz);
        send_item(cmd, idx, sz);
        if (k == PHASE_LEN / 2) drain_replies();
      end
      drain_replies();
    end
    calm = 1'b0;

    repeat (40) @(posedge clk_i);
    if (ledger.pending() != 0)
      ledger.report_mismatch($sformatf("%0d replies never came", ledger.pending()));
    if (ledger.mismatches == 0) begin
      $display("[worst_fit_partition_allocator_unit] OK");
    end else begin
      $display("[worst_fit_partition_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/wfpa_pkg.sv
rtl/wfpa_cell.sv
rtl/worst_fit_partition_allocator_unit.sv
rtl/wfpa_checker.sv
dv/worst_fit_partition_allocator_unit_tb.sv
